/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the top RTL file of the projection block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CVEP_ASSERT(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define CVEP_ASSERT_NR(lbl, prop, clk) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CVEP_ASSERT(lbl, prop, clk, rstn)
`define CVEP_ASSERT_NR(lbl, prop, clk)
`endif
`endif

/* hw/rtl/cvep_pkg.sv */
// ----------------------------------------------------------------------------
// Crease vertex edge projection package
// Widths, request types and helpers shared by the projection block.
// ----------------------------------------------------------------------------
`default_nettype none
package cvep_pkg;
  localparam int COORD_BITS = 32;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int LW = PW + 1;
  localparam int DOTW = PW + 2;
  localparam int NW = DW + PW;
  localparam int QW = DW;
  localparam int DNW = QW + 2;
  localparam int SQW = 2 * (DNW);
  localparam int RW = SQW + 2;
  localparam int LANE_LAT = QW + 7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] smooth_x;
    logic signed [COORD_BITS-1:0] smooth_y;
    logic signed [COORD_BITS-1:0] smooth_z;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic signed [COORD_BITS-1:0] base_z;
    logic signed [COORD_BITS-1:0] neighbor_a_x;
    logic signed [COORD_BITS-1:0] neighbor_a_y;
    logic signed [COORD_BITS-1:0] neighbor_a_z;
    logic signed [COORD_BITS-1:0] neighbor_b_x;
    logic signed [COORD_BITS-1:0] neighbor_b_y;
    logic signed [COORD_BITS-1:0] neighbor_b_z;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] result_x;
    logic signed [COORD_BITS-1:0] result_y;
    logic signed [COORD_BITS-1:0] result_z;
    logic                         degenerate;
  } out_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vec_t;

  typedef struct packed {
    logic                  ok;
    logic signed [DNW-1:0] dn_x;
    logic signed [DNW-1:0] dn_y;
    logic signed [DNW-1:0] dn_z;
    logic [RW-1:0]         res;
  } lane_res_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/cvep_lane.sv */
// ----------------------------------------------------------------------------
// Projection lane
// Projects the displacement onto one edge, pipelined with a bit-per-stage
// divider, and forms the squared residual.
// ----------------------------------------------------------------------------
`default_nettype none
module cvep_lane (
  input  wire logic                                clk_i,
  input  wire logic                                adv_i,
  input  wire logic signed [cvep_pkg::DW-1:0]      d_i [3],
  input  wire logic signed [cvep_pkg::DW-1:0]      e_i [3],
  output cvep_pkg::lane_res_t                      res_o
);
  localparam int DW = cvep_pkg::DW;
  localparam int PW = cvep_pkg::PW;
  localparam int LW = cvep_pkg::LW;
  localparam int DOTW = cvep_pkg::DOTW;
  localparam int NW = cvep_pkg::NW;
  localparam int QW = cvep_pkg::QW;
  localparam int DNW = cvep_pkg::DNW;
  localparam int SQW = cvep_pkg::SQW;
  localparam int RW = cvep_pkg::RW;

  logic [PW-1:0]          s1_sq_q [3];
  logic [PW-1:0]          s1_pm_q [3];
  logic                   s1_pn_q [3];
  logic [DW-1:0]          s1_em_q [3];
  logic                   s1_en_q [3];
  logic signed [DW-1:0]   s1_d_q [3];

  logic [LW-1:0]          s2_len_d, s2_len_q;
  logic signed [DOTW-1:0] s2_dot_d, s2_dot_q;
  logic [DW-1:0]          s2_em_q [3];
  logic                   s2_en_q [3];
  logic signed [DW-1:0]   s2_d_q [3];

  logic [PW-1:0]          s3_plo_q [3];
  logic [PW-1:0]          s3_phi_q [3];
  logic                   s3_pos_q;
  logic [LW-1:0]          s3_len_q;
  logic                   s3_en_q [3];
  logic signed [DW-1:0]   s3_d_q [3];

  logic [LW-1:0]          rem_d [3][QW+1];
  logic [LW-1:0]          rem_q [3][QW+1];
  logic [QW-1:0]          nlo_d [3][QW+1];
  logic [QW-1:0]          nlo_q [3][QW+1];
  logic [QW-1:0]          quo_d [3][QW+1];
  logic [QW-1:0]          quo_q [3][QW+1];
  logic [LW-1:0]          len_q [QW+1];
  logic                   ok_q [QW+1];
  logic                   en_q [QW+1][3];
  logic signed [DW-1:0]   dv_q [QW+1][3];

  logic signed [DNW-1:0]  s5_dn_d [3];
  logic signed [DNW-1:0]  s5_dn_q [3];
  logic signed [DW-1:0]   s5_d_q [3];
  logic                   s5_ok_q;

  logic [SQW-1:0]         s6_sq_d [3];
  logic [SQW-1:0]         s6_sq_q [3];
  logic signed [DNW-1:0]  s6_dn_q [3];
  logic                   s6_ok_q;

  logic [RW-1:0]          s7_res_q;
  logic signed [DNW-1:0]  s7_dn_q [3];
  logic                   s7_ok_q;

  always_comb begin
    s2_len_d = '0;
    s2_dot_d = '0;
    for (int c = 0; c < 3; c++) begin
      s2_len_d = s2_len_d + LW'(s1_sq_q[c]);
      if (s1_pn_q[c]) begin
        s2_dot_d = s2_dot_d - $signed(DOTW'(s1_pm_q[c]));
      end else begin
        s2_dot_d = s2_dot_d + $signed(DOTW'(s1_pm_q[c]));
      end
    end
  end

  always_comb begin
    logic [NW-1:0]   num;
    logic [LW-1:0]   rem2;
    logic            ge;
    logic [LW:0]     twice;
    logic [QW:0]     qv;
    logic signed [DNW:0] diff;
    logic [DNW-1:0]  dm;
    for (int c = 0; c < 3; c++) begin
      num = {s3_phi_q[c], {DW{1'b0}}} + NW'(s3_plo_q[c]);
      if (!s3_pos_q) begin
        num = '0;
      end
      rem_d[c][0] = LW'(num[NW-1:QW]);
      nlo_d[c][0] = num[QW-1:0];
      quo_d[c][0] = '0;
      for (int j = 0; j < QW; j++) begin
        rem2 = {rem_q[c][j][LW-2:0], nlo_q[c][j][QW-1]};
        ge = rem2 >= len_q[j];
        rem_d[c][j+1] = ge ? rem2 - len_q[j] : rem2;
        nlo_d[c][j+1] = {nlo_q[c][j][QW-2:0], 1'b0};
        quo_d[c][j+1] = {quo_q[c][j][QW-2:0], ge};
      end
      twice = {rem_q[c][QW], 1'b0};
      qv = {1'b0, quo_q[c][QW]} + (QW+1)'(twice >= {1'b0, len_q[QW]});
      s5_dn_d[c] = en_q[QW][c] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
      diff = $signed((DNW+1)'(s5_d_q[c])) - $signed((DNW+1)'(s5_dn_q[c]));
      dm = diff[DNW] ? DNW'(-diff) : DNW'(diff);
      s6_sq_d[c] = SQW'(dm) * SQW'(dm);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        s1_em_q[c] <= cvep_pkg::mag(e_i[c]);
        s1_sq_q[c] <= PW'(cvep_pkg::mag(e_i[c])) * PW'(cvep_pkg::mag(e_i[c]));
        s1_pm_q[c] <= PW'(cvep_pkg::mag(d_i[c])) * PW'(cvep_pkg::mag(e_i[c]));
        s1_pn_q[c] <= d_i[c][DW-1] ^ e_i[c][DW-1];
        s1_en_q[c] <= e_i[c][DW-1];
        s1_d_q[c]  <= d_i[c];
        s2_em_q[c] <= s1_em_q[c];
        s2_en_q[c] <= s1_en_q[c];
        s2_d_q[c]  <= s1_d_q[c];
        s3_plo_q[c] <= PW'(s2_em_q[c]) * PW'(s2_dot_q[DW-1:0]);
        s3_phi_q[c] <= PW'(s2_em_q[c]) * PW'(s2_dot_q[PW-1:DW]);
        s3_en_q[c] <= s2_en_q[c];
        s3_d_q[c]  <= s2_d_q[c];
        for (int j = 0; j <= QW; j++) begin
          rem_q[c][j] <= rem_d[c][j];
          nlo_q[c][j] <= nlo_d[c][j];
          quo_q[c][j] <= quo_d[c][j];
        end
        en_q[0][c] <= s3_en_q[c];
        dv_q[0][c] <= s3_d_q[c];
        for (int j = 0; j < QW; j++) begin
          en_q[j+1][c] <= en_q[j][c];
          dv_q[j+1][c] <= dv_q[j][c];
        end
        s5_dn_q[c] <= s5_dn_d[c];
        s5_d_q[c]  <= dv_q[QW][c];
        s6_sq_q[c] <= s6_sq_d[c];
        s6_dn_q[c] <= s5_dn_q[c];
        s7_dn_q[c] <= s6_dn_q[c];
      end
      s2_len_q <= s2_len_d;
      s2_dot_q <= s2_dot_d;
      s3_pos_q <= !s2_dot_q[DOTW-1] && (s2_dot_q != '0);
      s3_len_q <= s2_len_q;
      len_q[0] <= s3_len_q;
      ok_q[0]  <= s3_len_q != '0;
      for (int j = 0; j < QW; j++) begin
        len_q[j+1] <= len_q[j];
        ok_q[j+1]  <= ok_q[j];
      end
      s5_ok_q  <= ok_q[QW];
      s6_ok_q  <= s5_ok_q;
      s7_ok_q  <= s6_ok_q;
      s7_res_q <= RW'(s6_sq_q[0]) + RW'(s6_sq_q[1]) + RW'(s6_sq_q[2]);
    end
  end

  assign res_o.ok   = s7_ok_q;
  assign res_o.dn_x = s7_dn_q[0];
  assign res_o.dn_y = s7_dn_q[1];
  assign res_o.dn_z = s7_dn_q[2];
  assign res_o.res  = s7_res_q;
endmodule
`default_nettype wire

/* hw/rtl/cvep_merge.sv */
// ----------------------------------------------------------------------------
// Lane merge; with no usable edge the smoothed position passes through
// Picks the edge with smaller residual (A on a tie) and saturates the sum.
// ----------------------------------------------------------------------------
`default_nettype none
module cvep_merge (
  input  cvep_pkg::lane_res_t lane_a_i,
  input  cvep_pkg::lane_res_t lane_b_i,
  input  cvep_pkg::vec_t      smooth_i,
  input  cvep_pkg::vec_t      base_i,
  output cvep_pkg::out_req_t  req_o
);
  localparam int CB = cvep_pkg::COORD_BITS;
  localparam int DNW = cvep_pkg::DNW;

  function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] b,
                                                   input logic signed [DNW-1:0] dn);
    logic signed [DNW:0] v;
    v = $signed((DNW+1)'(b)) + $signed((DNW+1)'(dn));
    if (v > $signed((DNW+1)'({1'b0, {(CB-1){1'b1}}}))) begin
      sat_add = {1'b0, {(CB-1){1'b1}}};
    end else if (v < -$signed((DNW+1)'({1'b1, {(CB-1){1'b0}}}))) begin
      sat_add = {1'b1, {(CB-1){1'b0}}};
    end else begin
      sat_add = v[CB-1:0];
    end
  endfunction

  logic                pick_b;
  cvep_pkg::lane_res_t win;

  assign pick_b = lane_b_i.ok && (!lane_a_i.ok || (lane_b_i.res < lane_a_i.res));
  assign win    = pick_b ? lane_b_i : lane_a_i;

  always_comb begin
    if (!lane_a_i.ok && !lane_b_i.ok) begin
      req_o.result_x   = smooth_i.x;
      req_o.result_y   = smooth_i.y;
      req_o.result_z   = smooth_i.z;
      req_o.degenerate = 1'b1;
    end else begin
      req_o.result_x   = sat_add(base_i.x, win.dn_x);
      req_o.result_y   = sat_add(base_i.y, win.dn_y);
      req_o.result_z   = sat_add(base_i.z, win.dn_z);
      req_o.degenerate = 1'b0;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/crease_vertex_edge_projection.sv */
// ----------------------------------------------------------------------------
// Crease vertex edge projection
// Pulls a smoothed crease vertex back onto the nearer of its two hard edges.
//
// One request on the input channel carries the smoothed, base and both
// neighbor positions of a vertex; one request leaves on the output channel
// with the projected position and the degenerate flag. A request is taken at
// a clock edge with valid high and stall low.
// Two lanes, one per edge, run side by side and a merge stage picks the
// winner. The divider in each lane, one quotient bit per stage, sets most of
// the pipeline depth. Throughput is one request per cycle while it runs; the
// pipeline only halts when a result waits at the output while out_stall_i is
// high, and in_stall_o then rises.
// Reset clears all valid bits; no result is presented until new requests
// arrive.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module crease_vertex_edge_projection (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  cvep_pkg::in_req_t       in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cvep_pkg::out_req_t      out_req_o
);
  localparam int DW = cvep_pkg::DW;
  localparam int LAT = cvep_pkg::LANE_LAT;

  logic                 adv;
  logic                 v_q [LAT+1];
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] ea_q [3];
  logic signed [DW-1:0] eb_q [3];
  cvep_pkg::vec_t       sm_q [LAT+1];
  cvep_pkg::vec_t       bs_q [LAT+1];
  cvep_pkg::lane_res_t  lane_a, lane_b;
  cvep_pkg::out_req_t   merged;
  logic                 out_valid_q;
  cvep_pkg::out_req_t   out_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  function automatic logic signed [DW-1:0] sub(input logic signed [DW-2:0] a,
                                               input logic signed [DW-2:0] b);
    sub = $signed(DW'(a)) - $signed(DW'(b));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LAT; k++) begin
        v_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int k = 0; k < LAT; k++) begin
        v_q[k+1] <= v_q[k];
      end
      out_valid_q <= v_q[LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q[0]  <= sub(in_req_i.smooth_x, in_req_i.base_x);
      d_q[1]  <= sub(in_req_i.smooth_y, in_req_i.base_y);
      d_q[2]  <= sub(in_req_i.smooth_z, in_req_i.base_z);
      ea_q[0] <= sub(in_req_i.neighbor_a_x, in_req_i.base_x);
      ea_q[1] <= sub(in_req_i.neighbor_a_y, in_req_i.base_y);
      ea_q[2] <= sub(in_req_i.neighbor_a_z, in_req_i.base_z);
      eb_q[0] <= sub(in_req_i.neighbor_b_x, in_req_i.base_x);
      eb_q[1] <= sub(in_req_i.neighbor_b_y, in_req_i.base_y);
      eb_q[2] <= sub(in_req_i.neighbor_b_z, in_req_i.base_z);
      sm_q[0] <= {in_req_i.smooth_x, in_req_i.smooth_y, in_req_i.smooth_z};
      bs_q[0] <= {in_req_i.base_x, in_req_i.base_y, in_req_i.base_z};
      for (int k = 0; k < LAT; k++) begin
        sm_q[k+1] <= sm_q[k];
        bs_q[k+1] <= bs_q[k];
      end
      out_q <= merged;
    end
  end

  cvep_lane u_lane_a (
    .clk_i (clk_i),
    .adv_i (adv),
    .d_i   (d_q),
    .e_i   (ea_q),
    .res_o (lane_a)
  );

  cvep_lane u_lane_b (
    .clk_i (clk_i),
    .adv_i (adv),
    .d_i   (d_q),
    .e_i   (eb_q),
    .res_o (lane_b)
  );

  cvep_merge u_merge (
    .lane_a_i (lane_a),
    .lane_b_i (lane_b),
    .smooth_i (sm_q[LAT]),
    .base_i   (bs_q[LAT]),
    .req_o    (merged)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `CVEP_ASSERT(a_stall_needs_result, in_stall_o |-> out_valid_q, clk_i, rst_ni)
  `CVEP_ASSERT(a_accept_enters, (in_valid_i && !in_stall_o) |=> v_q[0], clk_i, rst_ni)
  `CVEP_ASSERT(a_tail_leaves, (v_q[LAT] && adv) |=> out_valid_o, clk_i, rst_ni)
endmodule
`default_nettype wire

/* dv/crease_vertex_edge_projection_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crease vertex edge projection checker
// Watches both channels. For every request taken at the input it predicts the
// projected vertex with exact wide arithmetic and queues the expectation. It
// then compares each delivered result field by field, in order.
// ----------------------------------------------------------------------------
module crease_vertex_edge_projection_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  cvep_pkg::in_req_t  in_req_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  cvep_pkg::out_req_t out_req_i,
  output int                 errors_o,
  output int                 pending_o
);
  typedef logic signed [255:0] wide_t;

  cvep_pkg::out_req_t projected_q[$];

  function automatic void project_on_edge(input longint d[3], input longint e[3],
                                          output bit ok, output longint dn[3],
                                          output wide_t res);
    wide_t len2, dot, num, q, r, df;
    len2 = 0;
    dot  = 0;
    for (int i = 0; i < 3; i++) begin
      len2 += wide_t'(e[i]) * wide_t'(e[i]);
      dot  += wide_t'(d[i]) * wide_t'(e[i]);
    end
    ok = (len2 != 0);
    res = 0;
    for (int i = 0; i < 3; i++) dn[i] = 0;
    if (!ok) return;
    if (dot > 0) begin
      for (int i = 0; i < 3; i++) begin
        num = (e[i] < 0 ? -wide_t'(e[i]) : wide_t'(e[i])) * dot;
        q = num / len2;
        r = num % len2;
        if (2 * r >= len2) q += 1;
        dn[i] = e[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    for (int i = 0; i < 3; i++) begin
      df = wide_t'(d[i]) - wide_t'(dn[i]);
      res += df * df;
    end
  endfunction

  function automatic cvep_pkg::out_req_t predict_projection(input cvep_pkg::in_req_t r);
    longint sm[3], bs[3], d[3], ea[3], eb[3], pa[3], pb[3], pick[3], v;
    bit oka, okb, use_b;
    wide_t ra, rb;
    cvep_pkg::out_req_t o;
    sm = '{longint'(r.smooth_x), longint'(r.smooth_y), longint'(r.smooth_z)};
    bs = '{longint'(r.base_x), longint'(r.base_y), longint'(r.base_z)};
    ea = '{longint'(r.neighbor_a_x), longint'(r.neighbor_a_y), longint'(r.neighbor_a_z)};
    eb = '{longint'(r.neighbor_b_x), longint'(r.neighbor_b_y), longint'(r.neighbor_b_z)};
    for (int i = 0; i < 3; i++) begin
      d[i]  = sm[i] - bs[i];
      ea[i] = ea[i] - bs[i];
      eb[i] = eb[i] - bs[i];
    end
    project_on_edge(d, ea, oka, pa, ra);
    project_on_edge(d, eb, okb, pb, rb);
    use_b = okb && (!oka || rb < ra);
    pick = use_b ? pb : pa;
    for (int i = 0; i < 3; i++) begin
      v = sm[i];
      if (oka || okb) begin
        v = bs[i] + pick[i];
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      case (i)
        0: o.result_x = v[31:0];
        1: o.result_y = v[31:0];
        default: o.result_z = v[31:0];
      endcase
    end
    o.degenerate = !(oka || okb);
    return o;
  endfunction

  assign pending_o = projected_q.size();

  always @(posedge clk_i) begin
    cvep_pkg::out_req_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        projected_q = {projected_q, predict_projection(in_req_i)};
      end
      if (out_valid_i && !out_stall_i) begin
        if (projected_q.size() == 0) begin
          $error("Result delivered with no request outstanding.");
          errors_o++;
        end else begin
          exp_r = projected_q.pop_front();
          if (out_req_i.result_x !== exp_r.result_x) begin
            $error("result_x expected %0d actual %0d", exp_r.result_x, out_req_i.result_x);
            errors_o++;
          end
          if (out_req_i.result_y !== exp_r.result_y) begin
            $error("result_y expected %0d actual %0d", exp_r.result_y, out_req_i.result_y);
            errors_o++;
          end
          if (out_req_i.result_z !== exp_r.result_z) begin
            $error("result_z expected %0d actual %0d", exp_r.result_z, out_req_i.result_z);
            errors_o++;
          end
          if (out_req_i.degenerate !== exp_r.degenerate) begin
            $error("degenerate expected %0b actual %0b", exp_r.degenerate,
                   out_req_i.degenerate);
            errors_o++;
          end
        end
      end
    end
  end
endmodule

/* dv/tb_crease_vertex_edge_projection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crease vertex edge projection testbench
// Drives directed and random vertex requests with random gaps and output
// stalls, including one long output hold that backs up the pipeline. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_crease_vertex_edge_projection;
  localparam int NUM_RANDOM = 400;
  localparam int DRAIN_CYCLES = 100;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cvep_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cvep_pkg::out_req_t out_req;
  int                 errors;
  int                 pending;
  int                 sent = 0;
  bit                 stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  crease_vertex_edge_projection dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_req_o(out_req)
  );

  crease_vertex_edge_projection_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_req_i(out_req),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] near(input logic [31:0] c, input int span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic cvep_pkg::in_req_t random_vertex();
    cvep_pkg::in_req_t r;
    int shape;
    int span;
    shape = $urandom_range(0, 9);
    span = (shape < 5) ? 256 : 32'h0100_0000;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (shape < 8) begin
      r.smooth_x = near(r.base_x, span);
      r.smooth_y = near(r.base_y, span);
      r.smooth_z = near(r.base_z, span);
      r.neighbor_a_x = near(r.base_x, span);
      r.neighbor_a_y = near(r.base_y, span);
      r.neighbor_a_z = near(r.base_z, span);
      r.neighbor_b_x = near(r.base_x, span);
      r.neighbor_b_y = near(r.base_y, span);
      r.neighbor_b_z = near(r.base_z, span);
    end
    if ($urandom_range(0, 9) == 0) begin
      r.neighbor_a_x = r.base_x;
      r.neighbor_a_y = r.base_y;
      r.neighbor_a_z = r.base_z;
    end
    if ($urandom_range(0, 9) == 0) begin
      r.neighbor_b_x = r.base_x;
      r.neighbor_b_y = r.base_y;
      r.neighbor_b_z = r.base_z;
    end
    return r;
  endfunction

  task automatic send_vertex(input cvep_pkg::in_req_t r);
    int g;
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
    g = gap_length();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] TWO = 32'h0002_0000;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Both edges of zero length: the smoothed position passes through.
    send_vertex({MAXC, MINC, 32'd5, {3{32'd7}}, {3{32'd7}}, {3{32'd7}}});
    // Edge A of zero length, B used.
    send_vertex({ONE, ONE, 32'd0, {3{32'd0}}, {3{32'd0}}, TWO, 32'd0, 32'd0});
    // Edge B of zero length, A used.
    send_vertex({ONE, ONE, 32'd0, {3{32'd0}}, 32'd0, TWO, 32'd0, {3{32'd0}}});
    // Dot product negative on both edges.
    send_vertex({-ONE, -ONE, -ONE, {3{32'd0}}, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0});
    // Dot product exactly zero.
    send_vertex({32'd0, 32'd0, ONE, {3{32'd0}}, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0});
    // Mirror edges giving equal residuals: A wins.
    send_vertex({ONE, ONE, 32'd0, {3{32'd0}}, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0});
    // Rounding at half a step.
    send_vertex({32'd1, 32'd0, 32'd0, {3{32'd0}}, 32'd2, 32'd2, 32'd0, {3{32'd0}}});
    send_vertex({-32'sd1, 32'd0, 32'd0, {3{32'd0}}, -32'sd2, 32'd2, 32'd0, {3{32'd0}}});
    // Results that land exactly on the high and low limits.
    send_vertex({MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MINC});
    send_vertex({MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC, MAXC});
    send_vertex({MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC, MINC, MINC, MAXC});
    // Every field at both extremes, then mixed, all-ones and zero fields.
    send_vertex({12{MAXC}});
    send_vertex({12{MINC}});
    send_vertex({MAXC, MAXC, MAXC, {3{32'd0}}, MAXC, 32'd0, 32'd0, 32'd0, MAXC, MINC});
    send_vertex({384{1'b1}});
    send_vertex('0);
    for (int n = 0; n < NUM_RANDOM; n++) send_vertex(random_vertex());
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    bit held;
    int hold_cycles;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && sent >= 120) begin
        held = 1'b1;
        out_stall <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 300) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        out_stall <= 1'b0;
      end else if (stim_done || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (gap_length() + 1) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cvep_pkg.sv
hw/rtl/cvep_lane.sv
hw/rtl/cvep_merge.sv
hw/rtl/crease_vertex_edge_projection.sv
dv/crease_vertex_edge_projection_checker.sv
dv/tb_crease_vertex_edge_projection.sv
